// ===== rtl/lrc_pkg.sv =====
// Shared types and constants for the LRU row index cache.
// Used by lrc_tag_store and lru_row_index_cache_unit; no dependencies.
package lrc_pkg;

  // Default parameter values
  localparam int CACHE_DEPTH_DEF = 16;
  localparam int INDEX_BITS_DEF  = 32;

  // Configuration register widths and reset values
  localparam int            CAP_W         = 5;
  localparam int            CFG_DATA_W    = 32;
  localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;

  typedef enum logic [0:0] {
    CFG_CACHE_CAPACITY = 1'b0,
    CFG_ROW_COUNT      = 1'b1
  } cfg_reg_e;

  typedef enum logic [0:0] {
    KIND_ACCESS = 1'b0,
    KIND_CLEAR  = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    ST_HIT           = 3'd0,
    ST_MISS_FILLED   = 3'd1,
    ST_MISS_UNFILLED = 3'd2,
    ST_OUT_OF_RANGE  = 3'd3,
    ST_CLEARED       = 3'd4
  } status_e;

endpackage

// ===== rtl/lrc_tag_store.sv =====
// Tag, valid and age rank storage with combinational lookup and registered LRU update.
// Depends on lrc_pkg.
module lrc_tag_store #(
  parameter int CACHE_DEPTH = lrc_pkg::CACHE_DEPTH_DEF,
  parameter int INDEX_BITS  = lrc_pkg::INDEX_BITS_DEF,
  localparam int RW = $clog2(CACHE_DEPTH),
  localparam int CW = $clog2(CACHE_DEPTH + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  lrc_pkg::kind_e             kind_i,
  input  logic [INDEX_BITS-1:0]      row_index_i,
  input  logic                       fill_ok_i,
  input  logic [lrc_pkg::CAP_W-1:0]  capacity_i,
  input  logic [INDEX_BITS-1:0]      row_count_i,
  output lrc_pkg::status_e           status_o,
  output logic                       evicted_valid_o,
  output logic [INDEX_BITS-1:0]      evicted_index_o,
  output logic [CW-1:0]              occupancy_o
);

  localparam int CMPW = (CW > lrc_pkg::CAP_W) ? CW : lrc_pkg::CAP_W;

  logic [INDEX_BITS-1:0] tag_q [CACHE_DEPTH];
  logic [CACHE_DEPTH-1:0] valid_q, valid_d;
  logic [RW-1:0] rank_q [CACHE_DEPTH];
  logic [RW-1:0] rank_d [CACHE_DEPTH];
  logic [CW-1:0] held_q, held_d;

  logic [CACHE_DEPTH-1:0] hit_vec, evict_vec, valid_after;
  logic                   hit_any, in_range, full, do_fill;
  logic [RW-1:0]          hit_rank, last_rank, free_slot;
  logic [CMPW-1:0]        cap_ext, eff_cap;
  logic [INDEX_BITS-1:0]  ev_tag;

  // Lookup: parallel compare, rank of the hit, victim selection
  always_comb begin
    hit_rank  = '0;
    ev_tag    = '0;
    last_rank = RW'(held_q - 1'b1);
    for (int i = 0; i < CACHE_DEPTH; i++) begin
      hit_vec[i] = valid_q[i] && (tag_q[i] == row_index_i);
      if (hit_vec[i]) hit_rank = hit_rank | rank_q[i];
      if (valid_q[i] && (rank_q[i] == last_rank)) ev_tag = ev_tag | tag_q[i];
    end
    hit_any  = |hit_vec;
    in_range = row_index_i < row_count_i;

    cap_ext = CMPW'(capacity_i);
    if (cap_ext == '0) begin
      eff_cap = CMPW'(1);
    end else if (cap_ext > CMPW'(CACHE_DEPTH)) begin
      eff_cap = CMPW'(CACHE_DEPTH);
    end else begin
      eff_cap = cap_ext;
    end
    full = CMPW'(held_q) >= eff_cap;

    // everything at rank cap-1 or older goes when the store is full
    for (int i = 0; i < CACHE_DEPTH; i++) begin
      evict_vec[i] = full && valid_q[i] && (CMPW'(rank_q[i]) >= (eff_cap - 1'b1));
    end
    valid_after = valid_q & ~evict_vec;

    free_slot = '0;
    for (int i = CACHE_DEPTH - 1; i >= 0; i--) begin
      if (!valid_after[i]) free_slot = RW'(i);
    end
  end

  // Next state and result
  always_comb begin
    valid_d         = valid_q;
    rank_d          = rank_q;
    held_d          = held_q;
    evicted_valid_o = 1'b0;
    evicted_index_o = '0;
    do_fill         = 1'b0;
    if (kind_i == lrc_pkg::KIND_CLEAR) begin
      status_o = lrc_pkg::ST_CLEARED;
      valid_d  = '0;
      for (int i = 0; i < CACHE_DEPTH; i++) rank_d[i] = '0;
      held_d   = '0;
    end else if (!in_range) begin
      status_o = lrc_pkg::ST_OUT_OF_RANGE;
    end else if (hit_any) begin
      status_o = lrc_pkg::ST_HIT;
      for (int i = 0; i < CACHE_DEPTH; i++) begin
        if (hit_vec[i]) begin
          rank_d[i] = '0;
        end else if (valid_q[i] && (rank_q[i] < hit_rank)) begin
          rank_d[i] = rank_q[i] + 1'b1;
        end
      end
    end else if (!fill_ok_i) begin
      status_o = lrc_pkg::ST_MISS_UNFILLED;
    end else begin
      status_o        = lrc_pkg::ST_MISS_FILLED;
      do_fill         = 1'b1;
      evicted_valid_o = full;
      evicted_index_o = full ? ev_tag : '0;
      for (int i = 0; i < CACHE_DEPTH; i++) begin
        if (RW'(i) == free_slot) begin
          valid_d[i] = 1'b1;
          rank_d[i]  = '0;
        end else if (valid_after[i]) begin
          rank_d[i] = rank_q[i] + 1'b1;
        end else begin
          valid_d[i] = 1'b0;
          rank_d[i]  = '0;
        end
      end
      held_d = full ? CW'(eff_cap) : held_q + 1'b1;
    end
    occupancy_o = held_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      held_q  <= '0;
      for (int i = 0; i < CACHE_DEPTH; i++) rank_q[i] <= '0;
    end else if (en_i) begin
      valid_q <= valid_d;
      held_q  <= held_d;
      rank_q  <= rank_d;
    end
  end

  // Tags carry no reset
  always_ff @(posedge clk_i) begin
    if (en_i && do_fill) tag_q[free_slot] <= row_index_i;
  end

  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= CW'(CACHE_DEPTH))
    else $error("held count above depth");

  a_held_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(held_q))
    else $error("held count does not match valid entries");

  a_unique_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(hit_vec))
    else $error("duplicate tag in store");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && (kind_i == lrc_pkg::KIND_CLEAR)) |=> (valid_q == '0) && (held_q == '0))
    else $error("clear left entries behind");

endmodule

// ===== rtl/lru_row_index_cache_unit.sv =====
// LRU row index cache: fully associative tag store with stream ports.
// Each accepted item passes through an input register, then a result register;
// throughput one item per cycle while m_axis_tready is high, set by the
// combinational parallel compare and rank update in lrc_tag_store.
// Reset: valid bits, age ranks and held count clear at once; tags stay
// undefined until written; cache_capacity resets to 16, row_count to 0.
module lru_row_index_cache_unit #(
  parameter int CACHE_DEPTH = lrc_pkg::CACHE_DEPTH_DEF,
  parameter int INDEX_BITS  = lrc_pkg::INDEX_BITS_DEF,
  localparam int CW     = $clog2(CACHE_DEPTH + 1),
  localparam int IN_W   = ((INDEX_BITS + 1 + 7) / 8) * 8,
  localparam int OUT_W  = ((3 + 1 + INDEX_BITS + CW + 7) / 8) * 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [0:0]                     cfg_index_i,
  input  logic [lrc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // input item stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [IN_W-1:0]                s_axis_tdata,  // row_index, fill_ok, zero pad
  input  logic                           s_axis_tuser,  // kind
  // result stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [OUT_W-1:0]               m_axis_tdata   // status, evicted_valid,
                                                        // evicted_index, occupancy, pad
);

  logic [lrc_pkg::CAP_W-1:0] capacity_q;
  logic [INDEX_BITS-1:0]     row_count_q;

  logic                  s1_valid_q;
  lrc_pkg::kind_e        s1_kind_q;
  logic [INDEX_BITS-1:0] s1_index_q;
  logic                  s1_fill_q;

  logic             out_valid_q;
  logic [OUT_W-1:0] out_data_q;

  logic advance;
  lrc_pkg::status_e      status;
  logic                  ev_valid;
  logic [INDEX_BITS-1:0] ev_index;
  logic [CW-1:0]         occupancy;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q  <= lrc_pkg::CAP_RESET;
      row_count_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (lrc_pkg::cfg_reg_e'(cfg_index_i))
        lrc_pkg::CFG_CACHE_CAPACITY: capacity_q  <= cfg_data_i[lrc_pkg::CAP_W-1:0];
        lrc_pkg::CFG_ROW_COUNT:      row_count_q <= INDEX_BITS'(cfg_data_i);
        default: ;
      endcase
    end
  end

  // item moves from the input register into the result register
  assign advance       = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) s1_valid_q <= s_axis_tvalid;
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      s1_kind_q  <= lrc_pkg::kind_e'(s_axis_tuser);
      s1_index_q <= s_axis_tdata[INDEX_BITS-1:0];
      s1_fill_q  <= s_axis_tdata[INDEX_BITS];
    end
    if (advance) begin
      out_data_q <= OUT_W'({occupancy, ev_index, ev_valid, status});
    end
  end

  lrc_tag_store #(
    .CACHE_DEPTH (CACHE_DEPTH),
    .INDEX_BITS  (INDEX_BITS)
  ) u_store (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (advance),
    .kind_i          (s1_kind_q),
    .row_index_i     (s1_index_q),
    .fill_ok_i       (s1_fill_q),
    .capacity_i      (capacity_q),
    .row_count_i     (row_count_q),
    .status_o        (status),
    .evicted_valid_o (ev_valid),
    .evicted_index_o (ev_index),
    .occupancy_o     (occupancy)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking bench for lru_row_index_cache_unit: directed and random stream items,
// predicted by a local LRU tag store model and checked field by field in order.
// Depends on lrc_pkg and the RTL top only.
module tb_top;

  localparam int IN_W       = 40;
  localparam int OUT_W      = 48;
  localparam int DEPTH      = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RAND_ITEMS = 1600;
  localparam int PHASES     = 8;

  typedef struct {
    lrc_pkg::status_e status;
    logic             ev_valid;
    logic [31:0]      ev_index;
    logic [4:0]       occupancy;
  } row_result_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [0:0]       cfg_index_i = '0;
  logic [31:0]      cfg_data_i = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata = '0;   // row_index, fill_ok, zero pad
  logic             s_axis_tuser = 1'b0; // kind
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;        // status, evicted_valid, evicted_index,
                                         // occupancy, pad

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  // expected results, oldest first
  row_result_t pending_results[$];

  // predictor state
  logic [4:0]  capacity_reg = lrc_pkg::CAP_RESET;
  logic [31:0] row_count_reg = '0;
  logic [31:0] tag_q[DEPTH];
  bit          valid_q[DEPTH];
  int unsigned rank_q[DEPTH];
  int unsigned held_count = 0;

  lru_row_index_cache_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  always @(negedge clk_i) begin
    m_axis_tready = rst_ni && ($urandom_range(99) >= recv_stall_pct);
  end

  // LRU lookup: updates the local store and returns the result for one item
  function automatic row_result_t lru_lookup(lrc_pkg::kind_e kind, logic [31:0] idx,
                                             logic fill);
    row_result_t res;
    int          hit_slot;
    int unsigned cap;
    int unsigned old_rank;
    res.status    = lrc_pkg::ST_HIT;
    res.ev_valid  = 1'b0;
    res.ev_index  = '0;
    hit_slot      = -1;
    if (kind == lrc_pkg::KIND_CLEAR) begin
      foreach (valid_q[i]) begin
        valid_q[i] = 1'b0;
        rank_q[i]  = 0;
      end
      held_count = 0;
      res.status = lrc_pkg::ST_CLEARED;
    end else if (idx >= row_count_reg) begin
      res.status = lrc_pkg::ST_OUT_OF_RANGE;
    end else begin
      for (int i = 0; i < DEPTH; i++) begin
        if (valid_q[i] && tag_q[i] == idx) begin
          hit_slot = i;
          break;
        end
      end
      if (hit_slot >= 0) begin
        old_rank = rank_q[hit_slot];
        foreach (valid_q[i]) begin
          if (valid_q[i] && rank_q[i] < old_rank) rank_q[i]++;
        end
        rank_q[hit_slot] = 0;
        res.status = lrc_pkg::ST_HIT;
      end else if (!fill) begin
        res.status = lrc_pkg::ST_MISS_UNFILLED;
      end else begin
        cap = (capacity_reg == 0) ? 1 : (capacity_reg > DEPTH) ? DEPTH : capacity_reg;
        // a lowered capacity can force several evictions; report the first
        while (held_count >= cap && held_count > 0) begin
          for (int i = 0; i < DEPTH; i++) begin
            if (valid_q[i] && rank_q[i] == held_count - 1) begin
              if (!res.ev_valid) begin
                res.ev_valid = 1'b1;
                res.ev_index = tag_q[i];
              end
              valid_q[i] = 1'b0;
              rank_q[i]  = 0;
              break;
            end
          end
          held_count--;
        end
        foreach (valid_q[i]) begin
          if (valid_q[i]) rank_q[i]++;
        end
        for (int i = 0; i < DEPTH; i++) begin
          if (!valid_q[i]) begin
            valid_q[i] = 1'b1;
            tag_q[i]   = idx;
            rank_q[i]  = 0;
            break;
          end
        end
        held_count++;
        res.status = lrc_pkg::ST_MISS_FILLED;
      end
    end
    res.occupancy = held_count[4:0];
    return res;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin : monitor
    row_result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result, expected none, got %0h", $time, m_axis_tdata);
        end else begin
          want = pending_results.pop_front();
          check_field("status", 32'(want.status), 32'(m_axis_tdata[2:0]));
          check_field("evicted_valid", 32'(want.ev_valid), 32'(m_axis_tdata[3]));
          check_field("evicted_index", want.ev_index, m_axis_tdata[35:4]);
          check_field("occupancy", 32'(want.occupancy), 32'(m_axis_tdata[40:36]));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        pending_results.insert(pending_results.size(),
                               lru_lookup(lrc_pkg::kind_e'(s_axis_tuser),
                                          s_axis_tdata[31:0], s_axis_tdata[32]));
      end
      if (cfg_valid_i && cfg_ready_o) begin
        if (lrc_pkg::cfg_reg_e'(cfg_index_i) == lrc_pkg::CFG_CACHE_CAPACITY) begin
          capacity_reg = cfg_data_i[4:0];
        end else begin
          row_count_reg = cfg_data_i;
        end
      end
    end
  end

  task automatic send_item(lrc_pkg::kind_e kind, logic [31:0] idx, logic fill);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tuser  = kind;
    s_axis_tdata  = {7'b0, fill, idx};
    s_axis_tvalid = 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // block is idle once every expected result has come back
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(lrc_pkg::cfg_reg_e reg_sel, logic [31:0] value);
    wait_idle();
    cfg_index_i = reg_sel;
    cfg_data_i  = value;
    cfg_valid_i = 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // reset values: row_count 0 puts every access out of range
  task automatic test_reset_state();
    send_item(lrc_pkg::KIND_ACCESS, 32'h0, 1'b1);
    send_item(lrc_pkg::KIND_ACCESS, 32'hFFFF_FFFF, 1'b1);
    send_item(lrc_pkg::KIND_CLEAR, 32'h0, 1'b0);
  endtask

  task automatic test_fill_and_evict();
    write_reg(lrc_pkg::CFG_ROW_COUNT, 32'hFFFF_FFFF);
    write_reg(lrc_pkg::CFG_CACHE_CAPACITY, 32'd3);
    send_item(lrc_pkg::KIND_ACCESS, 32'h0, 1'b0);
    send_item(lrc_pkg::KIND_ACCESS, 32'h0, 1'b1);
    send_item(lrc_pkg::KIND_ACCESS, 32'h0, 1'b0);
    send_item(lrc_pkg::KIND_ACCESS, 32'hFFFF_FFFE, 1'b1);
    send_item(lrc_pkg::KIND_ACCESS, 32'hFFFF_FFFF, 1'b1);
    send_item(lrc_pkg::KIND_ACCESS, 32'h5, 1'b1);
    send_item(lrc_pkg::KIND_ACCESS, 32'h0, 1'b1);
    send_item(lrc_pkg::KIND_ACCESS, 32'h6, 1'b1);
  endtask

  task automatic test_capacity_edges();
    write_reg(lrc_pkg::CFG_CACHE_CAPACITY, 32'd0);
    send_item(lrc_pkg::KIND_ACCESS, 32'd100, 1'b1);
    send_item(lrc_pkg::KIND_ACCESS, 32'd101, 1'b1);
    write_reg(lrc_pkg::CFG_CACHE_CAPACITY, 32'd31);
    for (int i = 0; i < 4; i++) send_item(lrc_pkg::KIND_ACCESS, 32'd200 + i, 1'b1);
    write_reg(lrc_pkg::CFG_CACHE_CAPACITY, 32'd2);
    send_item(lrc_pkg::KIND_ACCESS, 32'd200, 1'b0);
    send_item(lrc_pkg::KIND_ACCESS, 32'd300, 1'b1);
    send_item(lrc_pkg::KIND_CLEAR, 32'hFFFF_FFFF, 1'b1);
    send_item(lrc_pkg::KIND_ACCESS, 32'd300, 1'b0);
  endtask

  task automatic test_random_traffic();
    logic [4:0]  phase_cap[PHASES] = '{5'd16, 5'd4, 5'd31, 5'd1, 5'd0, 5'd7, 5'd16, 5'd3};
    int unsigned idle_pct[4] = '{0, 79, 0, 35};
    int unsigned stall_pct[4] = '{0, 0, 79, 35};
    logic [31:0] base;
    logic [31:0] idx;
    int unsigned sel;
    for (int p = 0; p < PHASES; p++) begin
      base = (p == 0) ? 32'h0 : (p == 6) ? 32'hFFFF_FF00 : ($urandom & 32'hFFFF_FF00);
      write_reg(lrc_pkg::CFG_CACHE_CAPACITY, 32'(phase_cap[p]));
      unique case (p % 4)
        0: write_reg(lrc_pkg::CFG_ROW_COUNT, 32'hFFFF_FFFF);
        1: write_reg(lrc_pkg::CFG_ROW_COUNT, base + 20);
        2: write_reg(lrc_pkg::CFG_ROW_COUNT, base + 12);
        default: write_reg(lrc_pkg::CFG_ROW_COUNT, $urandom);
      endcase
      send_idle_pct  = idle_pct[p % 4];
      recv_stall_pct = stall_pct[p % 4];
      for (int n = 0; n < RAND_ITEMS / PHASES; n++) begin
        sel = $urandom_range(99);
        // mostly a small pool of indices so hits and evictions are frequent
        idx = (sel < 14) ? $urandom : base + $urandom_range(0, 23);
        send_item((sel < 4) ? lrc_pkg::KIND_CLEAR : lrc_pkg::KIND_ACCESS, idx,
                  $urandom_range(99) < 75);
      end
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("[lru_row_index_cache_unit] ERROR");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_reset_state();
    test_fill_and_evict();
    test_capacity_edges();
    test_random_traffic();
    wait_idle();
    repeat (10) @(posedge clk_i);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("[lru_row_index_cache_unit] OK");
    end else begin
      $display("[lru_row_index_cache_unit] ERROR");
    end
    $finish;
  end

endmodule
